// ===== hdl/sacfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sacfp_pkg
// Shared types and constants for the sum/add checksum frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sacfp_pkg;

   localparam int unsigned BYTE_WIDTH      = 8;
   localparam int unsigned STATUS_WIDTH    = 2;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [BYTE_WIDTH-1:0] HEADER_BYTE_RESET      = 8'hAA;
   localparam logic [BYTE_WIDTH-1:0] ACCEPTED_ADDRESS_RESET = 8'h00;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_BYTE      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACCEPTED_ADDRESS = 2'd1;

   localparam logic KIND_PAYLOAD   = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_GOOD     = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_SUM  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_ADDR = 2'd2;

   typedef enum logic [6:0] {
      PH_HUNT = 7'b0000001,
      PH_ADDR = 7'b0000010,
      PH_CMD  = 7'b0000100,
      PH_LEN  = 7'b0001000,
      PH_DATA = 7'b0010000,
      PH_SUM  = 7'b0100000,
      PH_ADD  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic                    valid;
      logic                    item_kind;
      logic [BYTE_WIDTH-1:0]   payload_byte;
      logic [BYTE_WIDTH-1:0]   payload_index;
      logic [BYTE_WIDTH-1:0]   command_code;
      logic [BYTE_WIDTH-1:0]   frame_length;
      logic [STATUS_WIDTH-1:0] frame_status;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/sacfp_parser.sv =====
// ----------------------------------------------------------------------------
// sacfp_parser
// Frame state machine with running sum and sum of sums; one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module sacfp_parser
   import sacfp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [BYTE_WIDTH-1:0] rx_byte,
   input  wire logic [BYTE_WIDTH-1:0] header_byte,
   input  wire logic [BYTE_WIDTH-1:0] accepted_address,
   output result_type                 result
);

   phase_type             phase_ff, phase_in;
   logic [BYTE_WIDTH-1:0] address_ff, address_in;
   logic [BYTE_WIDTH-1:0] command_ff, command_in;
   logic [BYTE_WIDTH-1:0] length_ff, length_in;
   logic [BYTE_WIDTH-1:0] seen_ff, seen_in;
   logic [BYTE_WIDTH-1:0] sum_ff, sum_in;
   logic [BYTE_WIDTH-1:0] sos_ff, sos_in;
   logic [BYTE_WIDTH-1:0] rx_sum_ff, rx_sum_in;
   logic [BYTE_WIDTH-1:0] acc_sum;
   logic [BYTE_WIDTH-1:0] acc_sos;
   logic [BYTE_WIDTH-1:0] seen_next;

   assign acc_sum   = sum_ff + rx_byte;
   assign acc_sos   = sos_ff + acc_sum;
   assign seen_next = seen_ff + 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      address_in = address_ff;
      command_in = command_ff;
      length_in  = length_ff;
      seen_in    = seen_ff;
      sum_in     = sum_ff;
      sos_in     = sos_ff;
      rx_sum_in  = rx_sum_ff;
      result     = '0;
      case (phase_ff)
         PH_ADDR: begin
            sum_in     = acc_sum;
            sos_in     = acc_sos;
            address_in = rx_byte;
            phase_in   = PH_CMD;
         end
         PH_CMD: begin
            sum_in     = acc_sum;
            sos_in     = acc_sos;
            command_in = rx_byte;
            phase_in   = PH_LEN;
         end
         PH_LEN: begin
            sum_in    = acc_sum;
            sos_in    = acc_sos;
            length_in = rx_byte;
            seen_in   = '0;
            phase_in  = (rx_byte == '0) ? PH_SUM : PH_DATA;
         end
         PH_DATA: begin
            sum_in               = acc_sum;
            sos_in               = acc_sos;
            result.valid         = 1'b1;
            result.item_kind     = KIND_PAYLOAD;
            result.payload_byte  = rx_byte;
            result.payload_index = seen_ff;
            result.command_code  = command_ff;
            result.frame_length  = length_ff;
            result.frame_status  = STATUS_GOOD;
            seen_in              = seen_next;
            if (seen_next == length_ff) begin
               phase_in = PH_SUM;
            end
         end
         PH_SUM: begin
            rx_sum_in = rx_byte;
            phase_in  = PH_ADD;
         end
         PH_ADD: begin
            result.valid        = 1'b1;
            result.item_kind    = KIND_FRAME_END;
            result.command_code = command_ff;
            result.frame_length = length_ff;
            if (rx_sum_ff != sum_ff || rx_byte != sos_ff) begin
               result.frame_status = STATUS_BAD_SUM;
            end else if (address_ff != accepted_address) begin
               result.frame_status = STATUS_BAD_ADDR;
            end else begin
               result.frame_status = STATUS_GOOD;
            end
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
            if (rx_byte == header_byte) begin
               sum_in   = rx_byte;
               sos_in   = rx_byte;
               seen_in  = '0;
               phase_in = PH_ADDR;
            end
         end
      endcase
      if (!step) begin
         result.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         address_ff <= '0;
         command_ff <= '0;
         length_ff  <= '0;
         seen_ff    <= '0;
         sum_ff     <= '0;
         sos_ff     <= '0;
         rx_sum_ff  <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         address_ff <= address_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         seen_ff    <= seen_in;
         sum_ff     <= sum_in;
         sos_ff     <= sos_in;
         rx_sum_ff  <= rx_sum_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sacfp_out_stage.sv =====
// ----------------------------------------------------------------------------
// sacfp_out_stage
// Result register holding one beat toward the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sacfp_out_stage
   import sacfp_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  result_type                   result,
   input  wire logic                    rsp_stall,
   output logic                         out_free,
   output logic                         rsp_valid,
   output logic                         rsp_item_kind,
   output logic [BYTE_WIDTH-1:0]        rsp_payload_byte,
   output logic [BYTE_WIDTH-1:0]        rsp_payload_index,
   output logic [BYTE_WIDTH-1:0]        rsp_command_code,
   output logic [BYTE_WIDTH-1:0]        rsp_frame_length,
   output logic [STATUS_WIDTH-1:0]      rsp_frame_status
);

   logic       valid_ff;
   result_type data_ff;

   assign out_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_free) begin
         valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && result.valid) begin
         data_ff <= result;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_item_kind     = data_ff.item_kind;
   assign rsp_payload_byte  = data_ff.payload_byte;
   assign rsp_payload_index = data_ff.payload_index;
   assign rsp_command_code  = data_ff.command_code;
   assign rsp_frame_length  = data_ff.frame_length;
   assign rsp_frame_status  = data_ff.frame_status;

endmodule

`default_nettype wire

// ===== hdl/sum_add_check_frame_parser.sv =====
// ----------------------------------------------------------------------------
// sum_add_check_frame_parser
// A byte waits in the input register, then its result in the result register.
// Throughput: one byte per cycle, limited only by response stall.
// The input register and the result register each hold one beat.
// Reset (synchronous, high): parser hunts for the header, sums cleared,
// header byte 0xAA, accepted address 0, no beats held.
// ----------------------------------------------------------------------------
`default_nettype none

module sum_add_check_frame_parser
   import sacfp_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [BYTE_WIDTH-1:0]      req_rx_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_item_kind,
   output logic [BYTE_WIDTH-1:0]           rsp_payload_byte,
   output logic [BYTE_WIDTH-1:0]           rsp_payload_index,
   output logic [BYTE_WIDTH-1:0]           rsp_command_code,
   output logic [BYTE_WIDTH-1:0]           rsp_frame_length,
   output logic [STATUS_WIDTH-1:0]         rsp_frame_status,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [BYTE_WIDTH-1:0]      csr_write_data
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [BYTE_WIDTH-1:0] in_byte_ff;
   logic [BYTE_WIDTH-1:0] header_ff;
   logic [BYTE_WIDTH-1:0] accepted_ff;
   logic                  out_free;
   logic                  advance;
   logic                  req_accept;
   result_type            result;

   assign advance    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff   <= HEADER_BYTE_RESET;
         accepted_ff <= ACCEPTED_ADDRESS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_HEADER_BYTE:      header_ff   <= csr_write_data;
            CSR_ACCEPTED_ADDRESS: accepted_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   sacfp_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .rx_byte          (in_byte_ff),
      .header_byte      (header_ff),
      .accepted_address (accepted_ff),
      .result           (result)
   );

   sacfp_out_stage u_out_stage (
      .clock             (clock),
      .reset             (reset),
      .result            (result),
      .rsp_stall         (rsp_stall),
      .out_free          (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_command_code  (rsp_command_code),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_frame_status  (rsp_frame_status)
   );

endmodule

`default_nettype wire

// ===== hdl/sacfp_checker.sv =====
// ----------------------------------------------------------------------------
// sacfp_checker
// Port-level checks on the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sacfp_port_checks
   import sacfp_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_stall,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic                       rsp_item_kind,
   input wire logic [BYTE_WIDTH-1:0]      rsp_payload_byte,
   input wire logic [BYTE_WIDTH-1:0]      rsp_payload_index,
   input wire logic [BYTE_WIDTH-1:0]      rsp_command_code,
   input wire logic [BYTE_WIDTH-1:0]      rsp_frame_length,
   input wire logic [STATUS_WIDTH-1:0]    rsp_frame_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item_kind)
         && $stable(rsp_payload_byte) && $stable(rsp_payload_index)
         && $stable(rsp_command_code) && $stable(rsp_frame_length)
         && $stable(rsp_frame_status))
      else $error("stalled response beat changed");

   a_payload_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == KIND_PAYLOAD |-> rsp_frame_status == STATUS_GOOD)
      else $error("payload beat with nonzero status");

   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == KIND_FRAME_END
         |-> rsp_payload_byte == '0 && rsp_payload_index == '0)
      else $error("frame end beat with payload fields set");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_status == STATUS_GOOD
         || rsp_frame_status == STATUS_BAD_SUM || rsp_frame_status == STATUS_BAD_ADDR)
      else $error("undefined frame status");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("beats held after reset");

endmodule

bind sum_add_check_frame_parser sacfp_port_checks u_sacfp_port_checks (.*);

`default_nettype wire
